// ----- design/cds_pkg.sv -----
// shared types, constants and calendar functions for the date stepper
// no dependencies; used by cds_next and calendar_date_stepper
package cds_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MAX_YEAR_DEFAULT = 9999;

  // divisibility by 25 on a YEAR_W-bit value: multiply by the inverse of 25
  // modulo 2**YEAR_W, the product is a multiple of 25 exactly when it stays
  // at or below (2**YEAR_W - 1) / 25
  localparam logic [YEAR_W-1:0] INV25      = YEAR_W'(7209);
  localparam logic [YEAR_W-1:0] DIV25_MAX  = YEAR_W'(((2 ** YEAR_W) - 1) / 25);

  localparam logic [MONTH_W-1:0] JANUARY   = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] FEBRUARY  = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] DECEMBER  = MONTH_W'(12);

  typedef enum logic [2:0] {
    FN_LOAD       = 3'd0,
    FN_NEXT_DAY   = 3'd1,
    FN_PREV_DAY   = 3'd2,
    FN_NEXT_MONTH = 3'd3,
    FN_PREV_MONTH = 3'd4,
    FN_NEXT_YEAR  = 3'd5,
    FN_PREV_YEAR  = 3'd6
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LOAD = 2'd1,
    ST_LIMIT    = 2'd2
  } status_t;

  typedef struct packed {
    func_t              func;
    logic [YEAR_W-1:0]  load_year;
    logic [MONTH_W-1:0] load_month;
    logic [DAY_W-1:0]   load_day;
  } cds_in_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [DAY_W-1:0]   month_length;
    status_t            status;
  } cds_out_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  // leap year: divisible by 4 and not by 100, or divisible by 400
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [2*YEAR_W-1:0] prod;
    logic                by25;
    logic                by4;
    logic                by16;
    prod = {{YEAR_W{1'b0}}, y} * {{YEAR_W{1'b0}}, INV25};
    by25 = (prod[YEAR_W-1:0] <= DIV25_MAX);
    by4  = (y[1:0] == 2'b00);
    by16 = (y[3:0] == 4'b0000);
    return by4 && (!by25 || by16);
  endfunction

  // days in a month; codes outside 1..12 read as 31
  function automatic logic [DAY_W-1:0] month_len(input logic [YEAR_W-1:0] y,
                                                 input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] n;
    case (m)
      FEBRUARY:               n = is_leap(y) ? DAY_W'(29) : DAY_W'(28);
      4'd4, 4'd6, 4'd9, 4'd11: n = DAY_W'(30);
      default:                n = DAY_W'(31);
    endcase
    return n;
  endfunction

endpackage

// ----- design/cds_next.sv -----
// next-date logic: applies one request to the current date
// depends on cds_pkg
module cds_next #(
  parameter int unsigned MAX_YEAR = cds_pkg::MAX_YEAR_DEFAULT
) (
  input  cds_pkg::date_t   cur,
  input  cds_pkg::cds_in_t req,
  output cds_pkg::cds_out_t res
);
  import cds_pkg::*;

  typedef enum logic [2:0] {
    DS_KEEP,
    DS_INC,
    DS_DEC,
    DS_ONE,
    DS_LEN,
    DS_CLAMP,
    DS_LOAD
  } day_sel_t;

  localparam logic [YEAR_W-1:0] YEAR_TOP = YEAR_W'(MAX_YEAR);
  localparam logic [YEAR_W-1:0] YEAR_ONE = YEAR_W'(1);
  localparam logic [DAY_W-1:0]  DAY_ONE  = DAY_W'(1);

  logic              at_top;
  logic              at_bot;
  logic [DAY_W-1:0]  cur_len;
  logic [DAY_W-1:0]  load_len;
  logic              load_ok;
  logic [YEAR_W-1:0] nxt_year;
  logic [MONTH_W-1:0] nxt_month;
  logic [DAY_W-1:0]  nxt_len;
  logic [DAY_W-1:0]  nxt_day;
  day_sel_t          day_sel;
  status_t           st;

  // limits and checks on the current date and the load fields
  assign at_top   = (cur.year >= YEAR_TOP);
  assign at_bot   = (cur.year <= YEAR_ONE);
  assign cur_len  = month_len(cur.year, cur.month);
  assign load_len = month_len(req.load_year, req.load_month);
  assign load_ok  = (req.load_year != '0) && (req.load_year <= YEAR_TOP) &&
                    (req.load_month >= JANUARY) && (req.load_month <= DECEMBER) &&
                    (req.load_day != '0) && (req.load_day <= load_len);

  // command decode: new year and month, and how the day is formed
  always_comb begin
    nxt_year  = cur.year;
    nxt_month = cur.month;
    day_sel   = DS_KEEP;
    st        = ST_OK;
    unique case (req.func)
      FN_LOAD: begin
        if (load_ok) begin
          nxt_year  = req.load_year;
          nxt_month = req.load_month;
          day_sel   = DS_LOAD;
        end else begin
          st = ST_BAD_LOAD;
        end
      end
      FN_NEXT_DAY: begin
        if (cur.day < cur_len) begin
          day_sel = DS_INC;
        end else if (cur.month < DECEMBER) begin
          nxt_month = cur.month + MONTH_W'(1);
          day_sel   = DS_ONE;
        end else if (at_top) begin
          st = ST_LIMIT;
        end else begin
          nxt_year  = cur.year + YEAR_W'(1);
          nxt_month = JANUARY;
          day_sel   = DS_ONE;
        end
      end
      FN_PREV_DAY: begin
        if (cur.day > DAY_ONE) begin
          day_sel = DS_DEC;
        end else if (cur.month > JANUARY) begin
          nxt_month = cur.month - MONTH_W'(1);
          day_sel   = DS_LEN;
        end else if (at_bot) begin
          st = ST_LIMIT;
        end else begin
          // december always has 31 days
          nxt_year  = cur.year - YEAR_W'(1);
          nxt_month = DECEMBER;
          day_sel   = DS_LEN;
        end
      end
      FN_NEXT_MONTH: begin
        if (cur.month < DECEMBER) begin
          nxt_month = cur.month + MONTH_W'(1);
          day_sel   = DS_CLAMP;
        end else if (at_top) begin
          st = ST_LIMIT;
        end else begin
          nxt_year  = cur.year + YEAR_W'(1);
          nxt_month = JANUARY;
          day_sel   = DS_CLAMP;
        end
      end
      FN_PREV_MONTH: begin
        if (cur.month > JANUARY) begin
          nxt_month = cur.month - MONTH_W'(1);
          day_sel   = DS_CLAMP;
        end else if (at_bot) begin
          st = ST_LIMIT;
        end else begin
          nxt_year  = cur.year - YEAR_W'(1);
          nxt_month = DECEMBER;
          day_sel   = DS_CLAMP;
        end
      end
      FN_NEXT_YEAR: begin
        if (at_top) begin
          st = ST_LIMIT;
        end else begin
          nxt_year = cur.year + YEAR_W'(1);
          day_sel  = DS_CLAMP;
        end
      end
      FN_PREV_YEAR: begin
        if (at_bot) begin
          st = ST_LIMIT;
        end else begin
          nxt_year = cur.year - YEAR_W'(1);
          day_sel  = DS_CLAMP;
        end
      end
      default: begin
        // unused code leaves the date alone
        st = ST_OK;
      end
    endcase
  end

  // length of the resulting month, then the resulting day
  assign nxt_len = month_len(nxt_year, nxt_month);

  always_comb begin
    case (day_sel)
      DS_INC:   nxt_day = cur.day + DAY_W'(1);
      DS_DEC:   nxt_day = cur.day - DAY_W'(1);
      DS_ONE:   nxt_day = DAY_ONE;
      DS_LEN:   nxt_day = nxt_len;
      DS_CLAMP: nxt_day = (cur.day > nxt_len) ? nxt_len : cur.day;
      DS_LOAD:  nxt_day = req.load_day;
      default:  nxt_day = cur.day;
    endcase
  end

  assign res.year         = nxt_year;
  assign res.month        = nxt_month;
  assign res.day          = nxt_day;
  assign res.month_length = nxt_len;
  assign res.status       = st;

endmodule

// ----- design/calendar_date_stepper.sv -----
// calendar_date_stepper: a request passes the input register, then the date update
// into the result register.
// throughput one request per cycle while out_stall is low; the date register loads
// with the result register, so back-to-back requests see the previous result.
// synchronous active-low reset: date goes to 1 January of year 1, no request held.
// depends on cds_pkg and cds_next
module calendar_date_stepper #(
  parameter int unsigned MAX_YEAR = cds_pkg::MAX_YEAR_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cds_pkg::cds_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cds_pkg::cds_out_t  out_data
);
  import cds_pkg::*;

  logic     s1_valid_r;
  cds_in_t  s1_req_r;
  logic     out_valid_r;
  cds_out_t out_data_r;
  date_t    date_r;
  date_t    date_nxt;
  cds_out_t res_nxt;
  logic     s1_adv;

  // stage 1 moves on when the result register is free or being taken
  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_req_r <= in_data;
    end
  end

  // date update
  cds_next #(
    .MAX_YEAR(MAX_YEAR)
  ) u_next (
    .cur(date_r),
    .req(s1_req_r),
    .res(res_nxt)
  );

  assign date_nxt.year  = res_nxt.year;
  assign date_nxt.month = res_nxt.month;
  assign date_nxt.day   = res_nxt.day;

  // date register and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      date_r      <= '{year: YEAR_W'(1), month: JANUARY, day: DAY_W'(1)};
    end else begin
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_valid_r && s1_adv) begin
        date_r <= date_nxt;
      end
    end
    if (s1_valid_r && s1_adv) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
